@@ hw/rtl/mfau_pkg.sv @@
// shared types and constants for the motor feedback angle unwrap block
// no dependencies
package mfau_pkg;

  localparam int unsigned ENC_COUNTS_DEFAULT  = 8192;
  localparam int unsigned ACCUM_W_DEFAULT     = 48;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned RAW_W       = 16;
  localparam int unsigned POS_FIELD_W = 16;
  localparam int unsigned ROTOR_W     = 13;
  localparam int unsigned COUNT_OUT_W = 48;

  localparam int unsigned ANGLE_W      = 40;
  localparam int unsigned ANGLE_FRAC_W = 16;
  localparam int unsigned ROUND_HALF   = 32768;
  localparam logic [63:0] ANGLE_MAG_NEG = 64'h0000_0080_0000_0000;
  localparam logic [63:0] ANGLE_MAG_POS = 64'h0000_007F_FFFF_FFFF;

  localparam int unsigned DEG_PER_TURN = 360;
  localparam int unsigned GEAR_19_NUM  = 3591;
  localparam int unsigned GEAR_19_DEN  = 187;
  localparam int unsigned GEAR_36_NUM  = 36;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_MOTOR_TYPE = 1'b0;

  typedef enum logic [1:0] {
    MT_DIRECT  = 2'd0,
    MT_GEAR_19 = 2'd1,
    MT_GEAR_36 = 2'd2,
    MT_UNKNOWN = 2'd3
  } motor_type_e;

  typedef struct packed {
    logic                   known;
    motor_type_e            mtype;
    logic [POS_FIELD_W-1:0] pos;
    logic [WORD_W-1:0]      speed;
    logic [WORD_W-1:0]      current;
    logic [BYTE_W-1:0]      temp;
  } item_t;

endpackage

@@ hw/rtl/mfau_front.sv @@
// front end: takes frames, unpacks words, reduces the encoder modulo the count
// and tags each item with the motor type; depends on mfau_pkg
module mfau_front import mfau_pkg::*; #(
  parameter int unsigned ENCODER_COUNTS = ENC_COUNTS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [BYTE_W-1:0] enc_high_byte_i,
  input  logic [BYTE_W-1:0] enc_low_byte_i,
  input  logic [BYTE_W-1:0] speed_high_byte_i,
  input  logic [BYTE_W-1:0] speed_low_byte_i,
  input  logic [BYTE_W-1:0] current_high_byte_i,
  input  logic [BYTE_W-1:0] current_low_byte_i,
  input  logic [BYTE_W-1:0] temp_byte_i,
  input  motor_type_e       motor_type_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output item_t             item_o
);

  localparam int unsigned RAW_SPAN = 2 ** RAW_W;
  localparam logic [63:0] RECIP =
    ((64'd1 << 32) + 64'(ENCODER_COUNTS) - 64'd1) / 64'(ENCODER_COUNTS);
  localparam int unsigned RECIP_W = $clog2(RECIP + 64'd1);
  localparam int unsigned MUL_W   = RAW_W + RECIP_W;
  localparam int unsigned Q_W     = $clog2(RAW_SPAN / ENCODER_COUNTS + 1);

  logic              f1_v_q, f2_v_q;
  logic              f1_en, f2_en;
  logic [RAW_W-1:0]  raw_d, raw1_q;
  logic [MUL_W-1:0]  prod;
  logic [Q_W-1:0]    q1_q;
  logic [WORD_W-1:0] speed1_q, cur1_q;
  logic [BYTE_W-1:0] temp1_q;
  logic              known1_q;
  motor_type_e       mtype1_q;
  logic [31:0]       qe, pos_full;
  item_t             item_q;

  assign f2_en  = !f2_v_q || !q_full_i;
  assign f1_en  = !f1_v_q || f2_en;
  assign full_o = !f1_en;

  assign raw_d = {enc_high_byte_i, enc_low_byte_i};
  assign prod  = MUL_W'(raw_d) * MUL_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      if (f1_en) begin
        f1_v_q <= push_i;
      end
      if (f2_en) begin
        f2_v_q <= f1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && f1_en) begin
      raw1_q   <= raw_d;
      q1_q     <= prod[32 +: Q_W];
      speed1_q <= {speed_high_byte_i, speed_low_byte_i};
      cur1_q   <= {current_high_byte_i, current_low_byte_i};
      temp1_q  <= temp_byte_i;
      known1_q <= (motor_type_i != MT_UNKNOWN);
      mtype1_q <= motor_type_i;
    end
  end

  assign qe       = 32'(q1_q) * 32'(ENCODER_COUNTS);
  assign pos_full = 32'(raw1_q) - qe;

  always_ff @(posedge clk_i) begin
    if (f1_v_q && f2_en) begin
      item_q.known   <= known1_q;
      item_q.mtype   <= mtype1_q;
      item_q.pos     <= pos_full[POS_FIELD_W-1:0];
      item_q.speed   <= speed1_q;
      item_q.current <= cur1_q;
      item_q.temp    <= temp1_q;
    end
  end

  assign q_push_o = f2_v_q && !q_full_i;
  assign item_o   = item_q;

endmodule

@@ hw/rtl/mfau_queue.sv @@
// small queue of classified items between front and back end
// depends on mfau_pkg
module mfau_queue import mfau_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ hw/rtl/mfau_back.sv @@
// back end: multi-turn unwrap with saturating count, then pipelined scaling
// to shaft degrees and the result register; depends on mfau_pkg
module mfau_back import mfau_pkg::*; #(
  parameter int unsigned ENCODER_COUNTS = ENC_COUNTS_DEFAULT,
  parameter int unsigned ACCUM_WIDTH    = ACCUM_W_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  item_t                     item_i,
  output logic                      q_pop_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [ROTOR_W-1:0]        rotor_position_o,
  output logic signed [WORD_W-1:0]  speed_value_o,
  output logic signed [WORD_W-1:0]  current_value_o,
  output logic [BYTE_W-1:0]         temperature_o,
  output logic signed [COUNT_OUT_W-1:0] turn_count_total_o,
  output logic signed [ANGLE_W-1:0] shaft_angle_deg_o
);

  localparam int unsigned AW    = ACCUM_WIDTH;
  localparam int unsigned POS_W = $clog2(ENCODER_COUNTS);
  localparam int unsigned DW    = POS_W + 2;

  localparam logic [63:0] TURN_FX = 64'(DEG_PER_TURN) << 32;
  localparam logic [63:0] DIV_DIRECT = 64'(ENCODER_COUNTS);
  localparam logic [63:0] DIV_G19 = 64'(ENCODER_COUNTS) * 64'(GEAR_19_NUM);
  localparam logic [63:0] DIV_G36 = 64'(ENCODER_COUNTS) * 64'(GEAR_36_NUM);
  localparam logic [63:0] SCALE_DIRECT = (TURN_FX + DIV_DIRECT / 2) / DIV_DIRECT;
  localparam logic [63:0] SCALE_G19 =
    (TURN_FX * 64'(GEAR_19_DEN) + DIV_G19 / 2) / DIV_G19;
  localparam logic [63:0] SCALE_G36 = (TURN_FX + DIV_G36 / 2) / DIV_G36;
  localparam int unsigned SCALE_W = $clog2(SCALE_DIRECT + 64'd1);

  localparam int unsigned LO_W   = (AW + 1) / 2;
  localparam int unsigned HI_W   = AW - LO_W;
  localparam int unsigned PROD_W = AW + SCALE_W + 1;
  localparam int unsigned SUM_W  =
    (PROD_W > ANGLE_W + ANGLE_FRAC_W) ? PROD_W : ANGLE_W + ANGLE_FRAC_W;

  localparam logic signed [DW-1:0] COUNTS_S = DW'(ENCODER_COUNTS);
  localparam logic signed [AW-1:0] ACC_MAX  = {1'b0, {(AW - 1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN  = {1'b1, {(AW - 1){1'b0}}};

  // unwrap state
  logic                    started_q;
  logic [POS_W-1:0]        last_q;
  logic signed [AW-1:0]    acc_q;

  logic                    v1_q, v2_q, v3_q, v4_q, v5_q;
  logic                    en1, en2, en3, en4, en5;
  item_t                   it1_q, it2_q, it3_q, it4_q, it5_q;
  logic signed [AW-1:0]    cnt1_q, cnt2_q, cnt3_q, cnt4_q, cnt5_q;

  logic [POS_W-1:0]        pos;
  logic signed [DW-1:0]    d, w, step;
  logic [DW-1:0]           ad;
  logic [DW:0]             ad2;
  logic signed [AW:0]      sum;
  logic signed [AW-1:0]    sat, new_cnt;

  logic                    neg2_q, neg3_q, neg4_q;
  logic [AW-1:0]           mag2_q;
  logic [SCALE_W-1:0]      scale_d, scale2_q;
  logic [LO_W+SCALE_W-1:0] lo3_q;
  logic [HI_W+SCALE_W-1:0] hi3_q;
  logic [SUM_W-1:0]        sum4, r4, lim4;
  logic [ANGLE_W-1:0]      mag4_q;
  logic signed [ANGLE_W-1:0] angle, held_q, angle5_q;
  logic signed [63:0]      cnt_ext;

  assign en5     = !v5_q || pop_i;
  assign en4     = !v4_q || en5;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign q_pop_o = q_valid_i && en1;

  // unwrap step
  assign pos = item_i.pos[POS_W-1:0];
  assign d   = $signed({2'b00, pos}) - $signed({2'b00, last_q});
  assign ad  = d[DW-1] ? DW'(-d) : DW'(d);
  assign ad2 = {ad, 1'b0};

  always_comb begin
    if (d < 0) begin
      w = d + COUNTS_S;
    end else if (d > 0) begin
      w = d - COUNTS_S;
    end else begin
      w = '0;
    end
  end

  assign step    = (ad2 < (DW + 1)'(ENCODER_COUNTS)) ? d : w;
  assign sum     = $signed({acc_q[AW-1], acc_q}) + $signed((AW + 1)'(step));
  assign sat     = (sum[AW] != sum[AW-1]) ? (sum[AW] ? ACC_MIN : ACC_MAX)
                                           : sum[AW-1:0];
  assign new_cnt = !item_i.known ? acc_q : (started_q ? sat : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      last_q    <= '0;
      acc_q     <= '0;
      held_q    <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
    end else begin
      if (q_pop_o && item_i.known) begin
        started_q <= 1'b1;
        last_q    <= pos;
        acc_q     <= new_cnt;
      end
      if (en5 && v4_q && it4_q.known) begin
        held_q <= angle;
      end
      if (en1) v1_q <= q_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_comb begin
    unique case (it1_q.mtype)
      MT_DIRECT:  scale_d = SCALE_W'(SCALE_DIRECT);
      MT_GEAR_19: scale_d = SCALE_W'(SCALE_G19);
      MT_GEAR_36: scale_d = SCALE_W'(SCALE_G36);
      MT_UNKNOWN: scale_d = '0;
    endcase
  end

  // rounding and clamp of the scaled magnitude
  assign sum4 = (SUM_W'(hi3_q) << LO_W) + SUM_W'(lo3_q) + SUM_W'(ROUND_HALF);
  assign r4   = sum4 >> ANGLE_FRAC_W;
  assign lim4 = neg3_q ? SUM_W'(ANGLE_MAG_NEG) : SUM_W'(ANGLE_MAG_POS);

  assign angle = neg4_q ? $signed(-mag4_q) : $signed(mag4_q);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      it1_q  <= item_i;
      cnt1_q <= new_cnt;
    end
    if (en2 && v1_q) begin
      it2_q    <= it1_q;
      cnt2_q   <= cnt1_q;
      neg2_q   <= cnt1_q[AW-1];
      mag2_q   <= cnt1_q[AW-1] ? AW'(-cnt1_q) : AW'(cnt1_q);
      scale2_q <= scale_d;
    end
    if (en3 && v2_q) begin
      it3_q  <= it2_q;
      cnt3_q <= cnt2_q;
      neg3_q <= neg2_q;
      lo3_q  <= (LO_W + SCALE_W)'(mag2_q[LO_W-1:0]) * (LO_W + SCALE_W)'(scale2_q);
      hi3_q  <= (HI_W + SCALE_W)'(mag2_q[AW-1:LO_W]) * (HI_W + SCALE_W)'(scale2_q);
    end
    if (en4 && v3_q) begin
      it4_q  <= it3_q;
      cnt4_q <= cnt3_q;
      neg4_q <= neg3_q;
      mag4_q <= (r4 > lim4) ? lim4[ANGLE_W-1:0] : r4[ANGLE_W-1:0];
    end
    if (en5 && v4_q) begin
      it5_q    <= it4_q;
      cnt5_q   <= cnt4_q;
      angle5_q <= it4_q.known ? angle : held_q;
    end
  end

  assign cnt_ext = 64'(cnt5_q);

  assign empty_o            = !v5_q;
  assign rotor_position_o   = it5_q.pos[ROTOR_W-1:0];
  assign speed_value_o      = $signed(it5_q.speed);
  assign current_value_o    = $signed(it5_q.current);
  assign temperature_o      = it5_q.temp;
  assign turn_count_total_o = cnt_ext[COUNT_OUT_W-1:0];
  assign shaft_angle_deg_o  = angle5_q;

endmodule

@@ hw/rtl/motor_feedback_angle_unwrap.sv @@
// path: an input frame passes the front registers, the item queue and the back registers
// throughput: one frame per cycle; the front stalls only when the item queue
// is full, and the back pipeline stalls only when the result is not popped
// reset: clears unwrap state, held angle and all valid flags; motor type
// resets to unknown; no clearing pass is needed
// top level: config register, front end, item queue, back end; uses mfau_pkg
module motor_feedback_angle_unwrap import mfau_pkg::*; #(
  parameter int unsigned ENCODER_COUNTS = ENC_COUNTS_DEFAULT,
  parameter int unsigned ACCUM_WIDTH    = ACCUM_W_DEFAULT,
  parameter int unsigned QUEUE_DEPTH    = QUEUE_DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic [BYTE_W-1:0]             enc_high_byte_i,
  input  logic [BYTE_W-1:0]             enc_low_byte_i,
  input  logic [BYTE_W-1:0]             speed_high_byte_i,
  input  logic [BYTE_W-1:0]             speed_low_byte_i,
  input  logic [BYTE_W-1:0]             current_high_byte_i,
  input  logic [BYTE_W-1:0]             current_low_byte_i,
  input  logic [BYTE_W-1:0]             temp_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [ROTOR_W-1:0]            rotor_position_o,
  output logic signed [WORD_W-1:0]      speed_value_o,
  output logic signed [WORD_W-1:0]      current_value_o,
  output logic [BYTE_W-1:0]             temperature_o,
  output logic signed [COUNT_OUT_W-1:0] turn_count_total_o,
  output logic signed [ANGLE_W-1:0]     shaft_angle_deg_o
);

  motor_type_e motor_type_q;
  logic        reg_sel;
  logic        q_push, q_full, q_pop, q_empty;
  item_t       q_in, q_out;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_MOTOR_TYPE);
  assign prdata  = reg_sel ? PDATA_W'(motor_type_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_type_q <= MT_UNKNOWN;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      motor_type_q <= motor_type_e'(pwdata[1:0]);
    end
  end

  mfau_front #(
    .ENCODER_COUNTS(ENCODER_COUNTS)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push_i              (push),
    .full_o              (full),
    .enc_high_byte_i     (enc_high_byte_i),
    .enc_low_byte_i      (enc_low_byte_i),
    .speed_high_byte_i   (speed_high_byte_i),
    .speed_low_byte_i    (speed_low_byte_i),
    .current_high_byte_i (current_high_byte_i),
    .current_low_byte_i  (current_low_byte_i),
    .temp_byte_i         (temp_byte_i),
    .motor_type_i        (motor_type_q),
    .q_full_i            (q_full),
    .q_push_o            (q_push),
    .item_o              (q_in)
  );

  mfau_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  mfau_back #(
    .ENCODER_COUNTS(ENCODER_COUNTS),
    .ACCUM_WIDTH   (ACCUM_WIDTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (!q_empty),
    .item_i             (q_out),
    .q_pop_o            (q_pop),
    .empty_o            (empty),
    .pop_i              (pop),
    .rotor_position_o   (rotor_position_o),
    .speed_value_o      (speed_value_o),
    .current_value_o    (current_value_o),
    .temperature_o      (temperature_o),
    .turn_count_total_o (turn_count_total_o),
    .shaft_angle_deg_o  (shaft_angle_deg_o)
  );

  // front only backs up when the queue is full
  a_full_needs_queue_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> q_full)
    else $error("front stalled with room in the queue");

  // a result's rotor position lies inside one turn
  a_rotor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(rotor_position_o) < 32'(ENCODER_COUNTS)))
    else $error("rotor position beyond one turn");

  // register readback follows a completed write
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && reg_sel) |=>
      (prdata[1:0] == $past(pwdata[1:0])))
    else $error("motor type readback mismatch");

endmodule
